// File: rtl/pscr_pkg.sv
// Shared types and constants for the paired slot capacity reserver.
`timescale 1ns / 1ps

package pscr_pkg;

    // Default sizing
    localparam int NUM_SLOTS_DEF = 32;
    localparam int LOAD_BITS_DEF = 16;

    // Configuration port sizing
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_SLOT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LAST_SLOT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CAPACITY   = 2'd2;

    // Opcodes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef enum logic [1:0] {
        OUT_ACCEPTED    = 2'd0,
        OUT_RESCHEDULED = 2'd1,
        OUT_DENIED      = 2'd2,
        OUT_INVALID     = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_BOOK
    } t_state;

    // Input word
    typedef struct packed {
        logic        opcode;
        logic [4:0]  wanted_slot;
        logic [15:0] head_count;
    } t_in;

    // Result word
    typedef struct packed {
        t_outcome    outcome;
        logic [4:0]  granted_slot;
        logic [5:0]  now_slot;
        logic        day_over;
        logic [15:0] accepted_total;
        logic [15:0] rescheduled_total;
        logic [15:0] denied_total;
    } t_out;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic        inject;
        logic        shift;
        logic        clear;
        logic        book;
        logic [5:0]  start;
        logic [15:0] people;
        logic [15:0] capacity;
    } t_cell_ctl;

endpackage

// File: rtl/pscr_cell.sv
// One slot cell: holds the slot's load and the scan token, passes the token right.
`timescale 1ns / 1ps

module pscr_cell
    import pscr_pkg::*;
#(
    parameter int LOAD_BITS = LOAD_BITS_DEF,
    parameter int IDX       = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_prev_tok,
    input  logic      i_next_fit,
    output logic      o_tok,
    output logic      o_fit,
    output logic      o_hit
);

    localparam int LW = ((LOAD_BITS > 16) ? LOAD_BITS : 16) + 1;

    logic [LOAD_BITS-1:0] r_load;
    logic [LOAD_BITS-1:0] n_load;
    logic                 r_tok;
    logic                 n_tok;
    logic [LW-1:0]        w_sum;
    logic                 w_here;

    // Room check for this slot alone
    assign w_sum  = LW'(r_load) + LW'(i_ctl.people);
    assign o_fit  = (w_sum <= LW'(i_ctl.capacity));
    assign o_hit  = r_tok & o_fit & i_next_fit;
    assign o_tok  = r_tok;
    assign w_here = (IDX < 64) && (i_ctl.start == 6'(IDX));

    // Token: loaded at the start cell, then walks right one cell a cycle while shift is set
    always_comb begin
        if (i_ctl.inject) begin
            n_tok = w_here;
        end else if (i_ctl.clear) begin
            n_tok = 1'b0;
        end else if (i_ctl.shift) begin
            n_tok = i_prev_tok;
        end else begin
            n_tok = r_tok;
        end
    end

    // Booking adds to the token cell and the cell right of it
    always_comb begin
        if (i_ctl.book && (r_tok || i_prev_tok)) begin
            n_load = w_sum[LOAD_BITS-1:0];
        end else begin
            n_load = r_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= '0;
            r_tok  <= 1'b0;
        end else begin
            r_load <= n_load;
            r_tok  <= n_tok;
        end
    end

endmodule

// File: rtl/paired_slot_capacity_reserver.sv
// Top level: request sequencer, counters and the chain of slot cells.
`timescale 1ns / 1ps

// A tick word is taken with busy held low, and its result strobes on
// the next cycle. A request word that is refused up front (bad slot, too many
// people, or no pair left from its start slot) keeps busy high for 1 cycle.
// Otherwise a scan token is dropped at the start slot and moves one cell per
// cycle along the slot chain. The token steps past at most 30 slot pairs after
// the first one examined (with 32 slots); the word is booked when a pair has
// room and denied when the scan runs out. Its result strobes in the cycle busy
// falls, and a new word may be started in that same cycle. Results carry no
// back-pressure: o_valid is high for one cycle and the word must be taken
// then. Configuration writes must go in only while busy is low; the block
// itself does not enforce this.
module paired_slot_capacity_reserver
    import pscr_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int LOAD_BITS = LOAD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  t_in                      i_in,
    output logic                     o_valid,
    output t_out                     o_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int MAX_LAST = NUM_SLOTS - 1;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    t_state      r_state, n_state;
    logic [4:0]  r_first, n_first;
    logic [4:0]  r_last, n_last;
    logic [15:0] r_cap, n_cap;
    logic [5:0]  r_cur, n_cur;
    logic [15:0] r_acc, n_acc;
    logic [15:0] r_resc, n_resc;
    logic [15:0] r_den, n_den;
    t_in         r_item, n_item;
    logic [5:0]  r_idx, n_idx;
    logic        r_valid, n_valid;
    t_out        r_out, n_out;

    t_cell_ctl   w_ctl;
    logic [4:0]  w_last;
    logic [5:0]  w_start;
    logic        w_invalid;
    logic        w_no_pair;
    logic        w_scan_end;
    logic        w_hit;
    logic        w_accept;

    logic [NUM_SLOTS:0]   w_tok;
    logic [NUM_SLOTS:0]   w_fit;
    logic [NUM_SLOTS-1:0] w_hits;

    // Handshake and result ports
    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign o_valid  = r_valid;
    assign o_out    = r_out;

    // Usable last slot is bounded by the table size
    assign w_last = (32'(r_last) > MAX_LAST) ? 5'(MAX_LAST) : r_last;

    // Request checks on the latched word
    assign w_invalid  = (r_item.wanted_slot < r_first)
                     || ((6'(r_item.wanted_slot) + 6'd1) > 6'(w_last))
                     || (r_item.head_count > r_cap);
    assign w_start    = (6'(r_item.wanted_slot) < r_cur) ? r_cur
                                                           : 6'(r_item.wanted_slot);
    assign w_no_pair  = ((7'(w_start) + 7'd1) > 7'(w_last));
    assign w_scan_end = ((r_idx + 6'd1) == 6'(w_last));
    assign w_hit      = |w_hits;

    // Slot cell chain
    assign w_tok[0]         = 1'b0;
    assign w_fit[NUM_SLOTS] = 1'b0;

    for (genvar gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
        pscr_cell #(
            .LOAD_BITS (LOAD_BITS),
            .IDX       (gi)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_prev_tok (w_tok[gi]),
            .i_next_fit (w_fit[gi+1]),
            .o_tok      (w_tok[gi+1]),
            .o_fit      (w_fit[gi]),
            .o_hit      (w_hits[gi])
        );
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_in.opcode == OP_REQUEST)) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_invalid || w_no_pair) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_hit) begin
                    n_state = ST_BOOK;
                end else if (w_scan_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_BOOK: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        n_first = r_first;
        n_last  = r_last;
        n_cap   = r_cap;
        n_cur   = r_cur;
        n_acc   = r_acc;
        n_resc  = r_resc;
        n_den   = r_den;
        n_item  = r_item;
        n_idx   = r_idx;
        n_valid = 1'b0;
        n_out   = r_out;

        w_ctl          = '0;
        w_ctl.start    = w_start;
        w_ctl.people   = r_item.head_count;
        w_ctl.capacity = r_cap;

        n_out.outcome      = OUT_ACCEPTED;
        n_out.granted_slot = 5'd0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_item = i_in;
                    if (i_in.opcode == OP_TICK) begin
                        if (r_cur <= 6'(r_last)) begin
                            n_cur = r_cur + 6'd1;
                        end
                        n_valid = 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                if (w_invalid) begin
                    n_out.outcome = OUT_INVALID;
                    n_valid       = 1'b1;
                end else if (w_no_pair) begin
                    n_den         = sat_inc(r_den);
                    n_out.outcome = OUT_DENIED;
                    n_valid       = 1'b1;
                end else begin
                    w_ctl.inject = 1'b1;
                    n_idx        = w_start;
                end
            end
            ST_SCAN: begin
                if (w_hit) begin
                    n_idx = r_idx;
                end else if (w_scan_end) begin
                    w_ctl.clear   = 1'b1;
                    n_den         = sat_inc(r_den);
                    n_out.outcome = OUT_DENIED;
                    n_valid       = 1'b1;
                end else begin
                    w_ctl.shift = 1'b1;
                    n_idx       = r_idx + 6'd1;
                end
            end
            ST_BOOK: begin
                w_ctl.book         = 1'b1;
                w_ctl.clear        = 1'b1;
                n_out.granted_slot = r_idx[4:0];
                if (r_idx == 6'(r_item.wanted_slot)) begin
                    n_acc         = sat_inc(r_acc);
                    n_out.outcome = OUT_ACCEPTED;
                end else begin
                    n_resc        = sat_inc(r_resc);
                    n_out.outcome = OUT_RESCHEDULED;
                end
                n_valid = 1'b1;
            end
            default: ;
        endcase

        // Configuration writes (to be made only while idle; the block does not enforce this)
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FIRST_SLOT: begin
                    n_first = i_cfg_data[4:0];
                    n_cur   = 6'(i_cfg_data[4:0]);
                end
                REG_LAST_SLOT: n_last = i_cfg_data[4:0];
                REG_CAPACITY:  n_cap  = i_cfg_data[15:0];
                default: ;
            endcase
        end

        // Status fields of the result word
        n_out.now_slot          = n_cur;
        n_out.day_over          = (n_cur > 6'(n_last));
        n_out.accepted_total    = n_acc;
        n_out.rescheduled_total = n_resc;
        n_out.denied_total      = n_den;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_first <= 5'd0;
            r_last  <= 5'd31;
            r_cap   <= 16'd0;
            r_cur   <= 6'd0;
            r_acc   <= 16'd0;
            r_resc  <= 16'd0;
            r_den   <= 16'd0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            r_last  <= n_last;
            r_cap   <= n_cap;
            r_cur   <= n_cur;
            r_acc   <= n_acc;
            r_resc  <= n_resc;
            r_den   <= n_den;
            r_valid <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_idx  <= n_idx;
        r_out  <= n_out;
    end

endmodule

// File: rtl/pscr_checker.sv
// Port-level checks for the reserver, bound to the top level.
`timescale 1ns / 1ps

module pscr_checker
    import pscr_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_in  i_in,
    input logic o_valid,
    input t_out o_out
);

    // A tick word answers on the very next cycle
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_in.opcode == OP_TICK)) |=> o_valid)
        else $error("tick word gave no result on the next cycle");

    // A request word always goes busy
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_in.opcode == OP_REQUEST)) |=> busy)
        else $error("request word did not raise busy");

    // A result word is shown only once the block is free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Nothing granted on a denied or invalid request
    a_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_out.outcome == OUT_DENIED) || (o_out.outcome == OUT_INVALID)))
            |-> (o_out.granted_slot == 5'd0))
        else $error("slot granted on a refused request");

endmodule

bind paired_slot_capacity_reserver pscr_checker u_pscr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_in    (i_in),
    .o_valid (o_valid),
    .o_out   (o_out)
);

// File: tb/testbench.sv
// Self-checking testbench for the paired slot capacity reserver.
`timescale 1ns / 1ps

module testbench;
    import pscr_pkg::*;

    localparam int NSLOT = NUM_SLOTS_DEF;

    // Directed plan rows: register write, checked word, word with typed reply
    typedef enum logic [1:0] {
        ROW_REG,
        ROW_WORD,
        ROW_TYPED
    } t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        logic [CFG_IDX_BITS-1:0]   idx;
        logic [CFG_DATA_BITS-1:0]  data;
        t_in                       word;
        t_out                      given;
    } t_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    t_in                      i_in = '0;
    logic                     o_valid;
    t_out                     o_out;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    // Shadow of the block's state and registers
    logic [15:0] seat_load [NSLOT];
    logic [5:0]  cur_slot;
    logic [15:0] n_accept;
    logic [15:0] n_resched;
    logic [15:0] n_denied;
    logic [4:0]  r_first;
    logic [4:0]  r_last;
    logic [15:0] r_cap;

    t_out replies_due [$];
    t_row plan [$];
    t_out no_reply;
    int   fail_cnt = 0;
    int   idle_pct = 38;

    paired_slot_capacity_reserver u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Both slots of the pair have room for the party
    function automatic bit pair_room(int s, int people);
        if (s + 1 >= NSLOT) return 1'b0;
        return (int'(seat_load[s]) + people <= int'(r_cap)) &&
               (int'(seat_load[s + 1]) + people <= int'(r_cap));
    endfunction

    // Earliest fitting pair from base; -1 when none (last slot fits in the table)
    function automatic int first_fit(int base, int people);
        for (int s = base; s + 1 <= int'(r_last); s++) begin
            if (pair_room(s, people)) return s;
        end
        return -1;
    endfunction

    function automatic logic [15:0] bump(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Apply one word to the shadow state and return its reply
    function automatic t_out book_item(t_in w);
        t_out     r;
        t_outcome oc;
        int       want;
        int       people;
        int       at;
        want   = int'(w.wanted_slot);
        people = int'(w.head_count);
        at     = -1;
        oc     = OUT_ACCEPTED;
        if (w.opcode == OP_TICK) begin
            if (cur_slot <= {1'b0, r_last}) cur_slot = cur_slot + 6'd1;
        end else if (want < int'(r_first) || want + 1 > int'(r_last) ||
                     people > int'(r_cap)) begin
            oc = OUT_INVALID;
        end else if (want < int'(cur_slot)) begin
            // wanted slot already passed: search from now
            at = first_fit(int'(cur_slot), people);
            oc = (at < 0) ? OUT_DENIED : OUT_RESCHEDULED;
        end else if (pair_room(want, people)) begin
            at = want;
        end else begin
            at = first_fit(want + 1, people);
            oc = (at < 0) ? OUT_DENIED : OUT_RESCHEDULED;
        end
        if (at >= 0) begin
            seat_load[at]     = seat_load[at] + 16'(people);
            seat_load[at + 1] = seat_load[at + 1] + 16'(people);
        end
        if (w.opcode == OP_REQUEST) begin
            case (oc)
                OUT_ACCEPTED:    n_accept  = bump(n_accept);
                OUT_RESCHEDULED: n_resched = bump(n_resched);
                OUT_DENIED:      n_denied  = bump(n_denied);
                default: ;
            endcase
        end
        r.outcome           = oc;
        r.granted_slot      = (at >= 0) ? 5'(at) : 5'd0;
        r.now_slot          = cur_slot;
        r.day_over          = (cur_slot > {1'b0, r_last});
        r.accepted_total    = n_accept;
        r.rescheduled_total = n_resched;
        r.denied_total      = n_denied;
        return r;
    endfunction

    function automatic t_out reply(t_outcome oc, int g, int now, bit over,
                                   int acc, int res, int den);
        t_out r;
        r.outcome           = oc;
        r.granted_slot      = 5'(g);
        r.now_slot          = 6'(now);
        r.day_over          = over;
        r.accepted_total    = 16'(acc);
        r.rescheduled_total = 16'(res);
        r.denied_total      = 16'(den);
        return r;
    endfunction

    function automatic void add_reg(logic [CFG_IDX_BITS-1:0] idx, int data);
        t_row r;
        r.kind = ROW_REG;
        r.idx  = idx;
        r.data = 16'(data);
        plan.push_back(r);
    endfunction

    function automatic void add_word(logic op, int slot, int hc);
        t_row r;
        r.kind = ROW_WORD;
        r.word.opcode      = op;
        r.word.wanted_slot = 5'(slot);
        r.word.head_count  = 16'(hc);
        plan.push_back(r);
    endfunction

    function automatic void add_typed(logic op, int slot, int hc, t_out g);
        add_word(op, slot, hc);
        plan[$].kind  = ROW_TYPED;
        plan[$].given = g;
    endfunction

    // Random word: mostly well-formed requests inside the day, some ticks and noise
    function automatic t_in make_word();
        t_in w;
        int  pick;
        int  cap;
        pick = $urandom_range(0, 99);
        cap  = int'(r_cap);
        w.opcode      = OP_REQUEST;
        w.wanted_slot = 5'($urandom_range(0, 31));
        w.head_count  = 16'($urandom);
        if (pick < 9) begin
            w.opcode = OP_TICK;
        end else if (pick < 18) begin
            w.opcode = 1'($urandom);
        end else begin
            if (int'(r_last) - 1 >= int'(r_first))
                w.wanted_slot = 5'($urandom_range(int'(r_first), int'(r_last) - 1));
            if (pick < 22)
                w.head_count = 16'(cap);
            else if (pick < 25)
                w.head_count = 16'(cap + 1);
            else
                w.head_count = 16'($urandom_range(0, cap / 3 + 1));
        end
        return w;
    endfunction

    // Hold start low until every reply is in
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (replies_due.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx,
                             logic [CFG_DATA_BITS-1:0] data);
        drain();
        repeat (2) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_FIRST_SLOT: begin
                r_first  = data[4:0];
                cur_slot = {1'b0, data[4:0]};
            end
            REG_LAST_SLOT: r_last = data[4:0];
            REG_CAPACITY:  r_cap  = data;
            default: ;
        endcase
    endtask

    // Present one word, with a random gap first, and wait for it to be taken
    task automatic send_word(t_in w, bit typed, t_out given);
        t_out calc;
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        start <= 1'b1;
        i_in  <= w;
        do @(posedge i_clk); while (busy);
        calc = book_item(w);
        replies_due.push_back(typed ? given : calc);
    endtask

    task automatic set_day(int first, int last, int cap);
        write_reg(REG_LAST_SLOT, 16'(last));
        write_reg(REG_CAPACITY, 16'(cap));
        write_reg(REG_FIRST_SLOT, 16'(first));
    endtask

    task automatic log_miss(string what, t_out want);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%0t %s: exp oc=%0d g=%0d now=%0d over=%0b a=%0d r=%0d d=%0d | got oc=%0d g=%0d now=%0d over=%0b a=%0d r=%0d d=%0d",
                     $time, what, want.outcome, want.granted_slot, want.now_slot,
                     want.day_over, want.accepted_total, want.rescheduled_total,
                     want.denied_total, o_out.outcome, o_out.granted_slot,
                     o_out.now_slot, o_out.day_over, o_out.accepted_total,
                     o_out.rescheduled_total, o_out.denied_total);
    endtask

    // Reply checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            if (replies_due.size() == 0) begin
                log_miss("unexpected reply", no_reply);
            end else begin
                want = replies_due.pop_front();
                if (o_out.outcome !== want.outcome ||
                    o_out.granted_slot !== want.granted_slot ||
                    o_out.now_slot !== want.now_slot ||
                    o_out.day_over !== want.day_over ||
                    o_out.accepted_total !== want.accepted_total ||
                    o_out.rescheduled_total !== want.rescheduled_total ||
                    o_out.denied_total !== want.denied_total)
                    log_miss("reply mismatch", want);
            end
        end
    end

    // Stimulus
    initial begin
        int f;
        foreach (seat_load[k]) seat_load[k] = '0;
        cur_slot  = '0;
        n_accept  = '0;
        n_resched = '0;
        n_denied  = '0;
        r_first   = 5'd0;
        r_last    = 5'd31;
        r_cap     = 16'd0;

        // Zero capacity after reset, then full capacity at the top of the day
        add_typed(OP_REQUEST, 0, 0, reply(OUT_ACCEPTED, 0, 0, 0, 1, 0, 0));
        add_typed(OP_REQUEST, 0, 1, reply(OUT_INVALID, 0, 0, 0, 1, 0, 0));
        add_typed(OP_TICK, 0, 0, reply(OUT_ACCEPTED, 0, 1, 0, 1, 0, 0));
        add_reg(REG_CAPACITY, 65535);
        add_typed(OP_REQUEST, 31, 1, reply(OUT_INVALID, 0, 1, 0, 1, 0, 0));
        add_typed(OP_REQUEST, 30, 65535, reply(OUT_ACCEPTED, 30, 1, 0, 2, 0, 0));
        add_typed(OP_REQUEST, 29, 1, reply(OUT_DENIED, 0, 1, 0, 2, 0, 1));
        // passed slot, then first-fit past full slots
        add_word(OP_REQUEST, 0, 5);
        add_word(OP_REQUEST, 5, 100);
        add_word(OP_REQUEST, 5, 65435);
        add_word(OP_REQUEST, 5, 1);
        // capacity lowered under existing load
        add_reg(REG_CAPACITY, 50);
        add_word(OP_REQUEST, 5, 10);
        // slot before the first bookable one, short day running out
        add_reg(REG_FIRST_SLOT, 3);
        add_word(OP_REQUEST, 2, 0);
        add_reg(REG_LAST_SLOT, 4);
        add_word(OP_REQUEST, 3, 1);
        add_word(OP_REQUEST, 4, 1);
        add_word(OP_TICK, 31, 65535);
        add_word(OP_TICK, 31, 65535);
        add_word(OP_TICK, 31, 65535);
        add_word(OP_REQUEST, 3, 1);
        // one-slot days at both ends of the range
        add_reg(REG_FIRST_SLOT, 0);
        add_reg(REG_LAST_SLOT, 0);
        add_word(OP_REQUEST, 0, 0);
        add_word(OP_TICK, 0, 0);
        add_reg(REG_FIRST_SLOT, 31);
        add_reg(REG_LAST_SLOT, 31);
        add_word(OP_REQUEST, 31, 0);
        add_word(OP_TICK, 0, 0);
        add_word(OP_TICK, 0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            case (plan[k].kind)
                ROW_REG:   write_reg(plan[k].idx, plan[k].data);
                ROW_WORD:  send_word(plan[k].word, 1'b0, no_reply);
                ROW_TYPED: send_word(plan[k].word, 1'b1, plan[k].given);
                default: ;
            endcase
        end

        // Random days, each with new registers
        for (int n = 0; n < 1500; n++) begin
            if (n % 250 == 0) begin
                case (n / 250)
                    0: set_day(0, 31, 60);
                    1: set_day($urandom_range(0, 8), $urandom_range(20, 31), 300);
                    2: set_day(0, 31, 12);
                    3: begin
                        f = $urandom_range(0, 15);
                        set_day(f, $urandom_range(f + 1, 31), 3000);
                    end
                    4: set_day(0, 31, 65535);
                    default: set_day($urandom_range(0, 31), $urandom_range(0, 31),
                                     $urandom_range(0, 65535));
                endcase
            end
            if (n % 250 == 125) drain();
            idle_pct = (n < 500) ? 38 : (n < 1000) ? 57 : 0;
            send_word(make_word(), 1'b0, no_reply);
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
